// ===== design/tiof_pkg.sv =====
package tiof_pkg;

    localparam int unsigned CHROM_W    = 16;
    localparam int unsigned POS_W      = 31;
    localparam int unsigned FRAC_BITS  = 16;
    localparam int unsigned RATIO_W    = FRAC_BITS + 1;
    localparam int unsigned DIST_W     = 34;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = DIST_W;
    localparam int unsigned LANES      = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_THRESHOLD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_LIMIT  = CFG_IDX_W'(1);

    localparam logic [RATIO_W-1:0] RATIO_THRESHOLD_RESET = RATIO_W'(58982);
    localparam logic [DIST_W-1:0]  DISTANCE_LIMIT_RESET  = DIST_W'(5000);

    typedef struct packed {
        logic [CHROM_W-1:0] chrom_a;
        logic [POS_W-1:0]   start_a;
        logic [POS_W-1:0]   end_a;
        logic [CHROM_W-1:0] chrom_b;
        logic [POS_W-1:0]   start_b;
        logic [POS_W-1:0]   end_b;
        logic [CHROM_W-1:0] chrom_c;
        logic [POS_W-1:0]   start_c;
        logic [POS_W-1:0]   end_c;
    } in_beat_t;

    typedef struct packed {
        logic               match;
        logic [POS_W-1:0]   length_a;
        logic [POS_W-1:0]   length_b;
        logic [POS_W-1:0]   length_c;
        logic [RATIO_W-1:0] ratio_a;
        logic [RATIO_W-1:0] ratio_b;
        logic [RATIO_W-1:0] ratio_c;
        logic [DIST_W-1:0]  distance_sum;
    } out_beat_t;

    // one divider lane: divisor, partial remainder, quotient bits so far
    typedef struct packed {
        logic [POS_W-1:0]   div;
        logic [POS_W-1:0]   rem;
        logic [RATIO_W-1:0] quo;
    } lane_t;

    typedef struct packed {
        lane_t [LANES-1:0]            lane;
        logic  [LANES-1:0][POS_W-1:0] len;
        logic  [DIST_W-1:0]           dist_sum;
        logic                         chrom_eq;
        logic                         common;
    } work_t;

endpackage

// ===== design/tiof_front.sv =====
module tiof_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tiof_pkg::in_beat_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output tiof_pkg::work_t   m_data
);
    import tiof_pkg::*;

    typedef struct packed {
        logic [LANES-1:0][POS_W-1:0] len;
        logic [POS_W-1:0]            hi_start;
        logic [POS_W-1:0]            lo_end;
        logic [5:0][POS_W-1:0]       adiff;
        logic                        chrom_eq;
    } prep_t;

    prep_t                prep_next, prep_reg;
    logic                 v1_reg, v2_reg;
    logic                 rdy1, rdy2;
    work_t                work_next, work_reg;

    logic [LANES-1:0][POS_W-1:0] s_pos, e_pos;
    logic [POS_W-1:0]            hs_ab, le_ab;

    function automatic logic [POS_W-1:0] absdiff(input logic [POS_W-1:0] x,
                                                 input logic [POS_W-1:0] y);
        return (x >= y) ? (x - y) : (y - x);
    endfunction

    assign rdy2    = !v2_reg || m_ready;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;
    assign m_valid = v2_reg;
    assign m_data  = work_reg;

    always_comb begin
        s_pos[0] = s_data.start_a;
        s_pos[1] = s_data.start_b;
        s_pos[2] = s_data.start_c;
        e_pos[0] = s_data.end_a;
        e_pos[1] = s_data.end_b;
        e_pos[2] = s_data.end_c;
        for (int i = 0; i < LANES; i++) begin
            prep_next.len[i] = (e_pos[i] > s_pos[i]) ? (e_pos[i] - s_pos[i]) : '0;
        end
        hs_ab = (s_pos[0] >= s_pos[1]) ? s_pos[0] : s_pos[1];
        le_ab = (e_pos[0] <= e_pos[1]) ? e_pos[0] : e_pos[1];
        prep_next.hi_start = (hs_ab >= s_pos[2]) ? hs_ab : s_pos[2];
        prep_next.lo_end   = (le_ab <= e_pos[2]) ? le_ab : e_pos[2];
        prep_next.adiff[0] = absdiff(s_pos[0], s_pos[1]);
        prep_next.adiff[1] = absdiff(e_pos[0], e_pos[1]);
        prep_next.adiff[2] = absdiff(s_pos[0], s_pos[2]);
        prep_next.adiff[3] = absdiff(e_pos[0], e_pos[2]);
        prep_next.adiff[4] = absdiff(s_pos[1], s_pos[2]);
        prep_next.adiff[5] = absdiff(e_pos[1], e_pos[2]);
        prep_next.chrom_eq = (s_data.chrom_a == s_data.chrom_b)
                          && (s_data.chrom_b == s_data.chrom_c);
    end

    logic                 common;
    logic [POS_W-1:0]     overlap;
    logic [POS_W-1:0]     ov_l;
    logic [POS_W-1:0]     div_l;
    logic                 top_bit;

    always_comb begin
        common  = prep_reg.lo_end >= prep_reg.hi_start;
        overlap = prep_reg.lo_end - prep_reg.hi_start;
        work_next.len      = prep_reg.len;
        work_next.chrom_eq = prep_reg.chrom_eq;
        work_next.common   = common;
        work_next.dist_sum = DIST_W'(prep_reg.adiff[0]) + DIST_W'(prep_reg.adiff[1])
                           + DIST_W'(prep_reg.adiff[2]) + DIST_W'(prep_reg.adiff[3])
                           + DIST_W'(prep_reg.adiff[4]) + DIST_W'(prep_reg.adiff[5]);
        ov_l    = '0;
        div_l   = '0;
        top_bit = 1'b0;
        for (int i = 0; i < LANES; i++) begin
            // empty interval or no overlap: divide 0 by 1 so the quotient stays 0
            if (common && (prep_reg.len[i] != '0)) begin
                ov_l  = overlap;
                div_l = prep_reg.len[i];
            end else begin
                ov_l  = '0;
                div_l = POS_W'(1);
            end
            // overlap never exceeds the length, so the integer bit is overlap == length
            top_bit = (ov_l == div_l);
            work_next.lane[i].div = div_l;
            work_next.lane[i].rem = top_bit ? '0 : ov_l;
            work_next.lane[i].quo = {{(RATIO_W-1){1'b0}}, top_bit};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
        end
        if (rdy1 && s_valid) begin
            prep_reg <= prep_next;
        end
        if (rdy2 && v1_reg) begin
            work_reg <= work_next;
        end
    end

endmodule

// ===== design/tiof_div_cell.sv =====
module tiof_div_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  tiof_pkg::work_t s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output tiof_pkg::work_t m_data
);
    import tiof_pkg::*;

    logic  valid_reg;
    work_t data_next, data_reg;

    logic [POS_W:0] shifted [LANES];
    logic [POS_W:0] sub     [LANES];
    logic           ge      [LANES];

    assign s_ready = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    // one restoring step per lane: next quotient bit
    always_comb begin
        data_next = s_data;
        for (int i = 0; i < LANES; i++) begin
            shifted[i] = {s_data.lane[i].rem, 1'b0};
            sub[i]     = shifted[i] - {1'b0, s_data.lane[i].div};
            ge[i]      = shifted[i] >= {1'b0, s_data.lane[i].div};
            data_next.lane[i].rem = ge[i] ? sub[i][POS_W-1:0] : shifted[i][POS_W-1:0];
            data_next.lane[i].quo = {s_data.lane[i].quo[RATIO_W-2:0], ge[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== design/tiof_judge.sv =====
module tiof_judge (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [tiof_pkg::RATIO_W-1:0]   ratio_threshold,
    input  logic [tiof_pkg::DIST_W-1:0]    distance_limit,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  tiof_pkg::work_t                s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output tiof_pkg::out_beat_t            m_data
);
    import tiof_pkg::*;

    logic      valid_reg;
    out_beat_t data_next, data_reg;
    logic      ok;

    assign s_ready = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    always_comb begin
        ok = s_data.chrom_eq && s_data.common && (s_data.dist_sum <= distance_limit);
        for (int i = 0; i < LANES; i++) begin
            ok = ok && (s_data.len[i] != '0) && (s_data.lane[i].quo > ratio_threshold);
        end
        data_next.match        = ok;
        data_next.length_a     = s_data.len[0];
        data_next.length_b     = s_data.len[1];
        data_next.length_c     = s_data.len[2];
        data_next.ratio_a      = s_data.lane[0].quo;
        data_next.ratio_b      = s_data.lane[1].quo;
        data_next.ratio_c      = s_data.lane[2].quo;
        data_next.distance_sum = s_data.dist_sum;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== design/three_interval_overlap_filter.sv =====
// channel   ports                     beat            handshake
// input     s_valid s_ready s_data    in_beat_t       valid/ready
// result    m_valid m_ready m_data    out_beat_t      valid/ready
// config    cfg_we cfg_index cfg_wdata  write only    write on cfg_we
//
// One triple per cycle sustained while m_ready holds; the pipe is two front stages,
// a row of 16 divider cells (one ratio bit each), one output stage.
// Every stage has its own valid and stalls only when the stage after it is full.
// Synchronous active-low reset empties the pipe and loads the register defaults.
module three_interval_overlap_filter (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  tiof_pkg::in_beat_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output tiof_pkg::out_beat_t               m_data,
    input  logic                              cfg_we,
    input  logic [tiof_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tiof_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import tiof_pkg::*;

    logic [RATIO_W-1:0] ratio_threshold_reg;
    logic [DIST_W-1:0]  distance_limit_reg;

    work_t stage_data  [FRAC_BITS+1];
    logic  stage_valid [FRAC_BITS+1];
    logic  stage_ready [FRAC_BITS+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ratio_threshold_reg <= RATIO_THRESHOLD_RESET;
            distance_limit_reg  <= DISTANCE_LIMIT_RESET;
        end else if (cfg_we) begin
            if (cfg_index == CFG_RATIO_THRESHOLD) begin
                ratio_threshold_reg <= cfg_wdata[RATIO_W-1:0];
            end
            if (cfg_index == CFG_DISTANCE_LIMIT) begin
                distance_limit_reg <= cfg_wdata[DIST_W-1:0];
            end
        end
    end

    tiof_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (stage_valid[0]),
        .m_ready (stage_ready[0]),
        .m_data  (stage_data[0])
    );

    for (genvar g = 0; g < FRAC_BITS; g++) begin : g_cell
        tiof_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .s_valid (stage_valid[g]),
            .s_ready (stage_ready[g]),
            .s_data  (stage_data[g]),
            .m_valid (stage_valid[g+1]),
            .m_ready (stage_ready[g+1]),
            .m_data  (stage_data[g+1])
        );
    end

    tiof_judge u_judge (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ratio_threshold (ratio_threshold_reg),
        .distance_limit  (distance_limit_reg),
        .s_valid         (stage_valid[FRAC_BITS]),
        .s_ready         (stage_ready[FRAC_BITS]),
        .s_data          (stage_data[FRAC_BITS]),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data)
    );

endmodule

// ===== dv/three_interval_overlap_filter_test.sv =====
`timescale 1ns / 1ps

module three_interval_overlap_filter_test;

    import tiof_pkg::*;

    localparam int unsigned PIPE_LATENCY     = 19;
    localparam int unsigned WATCHDOG_LIMIT   = 5000;
    localparam int unsigned ITEMS_PER_SEG    = 100;
    localparam int unsigned MAX_REPORTS      = 10;
    localparam logic [POS_W-1:0] POS_MAX     = '1;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_SUCH_REG = CFG_IDX_W'(2);

    typedef enum int unsigned {
        BREAK_CHROM,
        BREAK_REVERSE,
        BREAK_EMPTY,
        BREAK_APART,
        BREAK_TOUCH
    } break_kind_e;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    in_beat_t   s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    out_beat_t  m_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    logic [RATIO_W-1:0] ratio_threshold_q = RATIO_THRESHOLD_RESET;
    logic [DIST_W-1:0]  distance_limit_q  = DISTANCE_LIMIT_RESET;

    out_beat_t   pending_results[$];
    int unsigned src_idle_pct  = 0;
    int unsigned snk_idle_pct  = 0;
    int unsigned triples_sent  = 0;
    int unsigned results_seen  = 0;
    int unsigned matches_seen  = 0;
    int unsigned mismatches    = 0;
    int unsigned quiet_cycles  = 0;

    three_interval_overlap_filter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [63:0] gap_between(logic [63:0] x, logic [63:0] y);
        return (x >= y) ? x - y : y - x;
    endfunction

    function automatic out_beat_t predict_overlap(in_beat_t t);
        logic [63:0] st[3];
        logic [63:0] en[3];
        logic [63:0] len[3];
        logic [63:0] ratio[3];
        logic [63:0] hi_start, lo_end, overlap, dist_total;
        logic        common, ok;
        out_beat_t   o;
        int          i, j;
        st[0] = 64'(t.start_a); st[1] = 64'(t.start_b); st[2] = 64'(t.start_c);
        en[0] = 64'(t.end_a);   en[1] = 64'(t.end_b);   en[2] = 64'(t.end_c);
        hi_start = '0;
        lo_end   = '1;
        for (i = 0; i < 3; i++) begin
            len[i] = (en[i] > st[i]) ? en[i] - st[i] : '0;
            if (st[i] > hi_start) hi_start = st[i];
            if (en[i] < lo_end) lo_end = en[i];
        end
        common  = lo_end >= hi_start;
        overlap = common ? lo_end - hi_start : '0;
        dist_total = '0;
        for (i = 0; i < 3; i++) begin
            for (j = i + 1; j < 3; j++) begin
                dist_total += gap_between(st[i], st[j]) + gap_between(en[i], en[j]);
            end
        end
        ok = (t.chrom_a == t.chrom_b) && (t.chrom_b == t.chrom_c) && common
            && (dist_total <= 64'(distance_limit_q));
        for (i = 0; i < 3; i++) begin
            if (!common || len[i] == '0) begin
                ratio[i] = '0;
            end else begin
                ratio[i] = (overlap << FRAC_BITS) / len[i];
                if (ratio[i] > (64'd1 << FRAC_BITS)) ratio[i] = 64'd1 << FRAC_BITS;
            end
            ok = ok && (len[i] != '0) && (ratio[i] > 64'(ratio_threshold_q));
        end
        o.match        = ok;
        o.length_a     = len[0][POS_W-1:0];
        o.length_b     = len[1][POS_W-1:0];
        o.length_c     = len[2][POS_W-1:0];
        o.ratio_a      = ratio[0][RATIO_W-1:0];
        o.ratio_b      = ratio[1][RATIO_W-1:0];
        o.ratio_c      = ratio[2][RATIO_W-1:0];
        o.distance_sum = dist_total[DIST_W-1:0];
        return o;
    endfunction

    function automatic in_beat_t make_triple(
        logic [CHROM_W-1:0] ca, logic [POS_W-1:0] sa, logic [POS_W-1:0] ea,
        logic [CHROM_W-1:0] cb, logic [POS_W-1:0] sb, logic [POS_W-1:0] eb,
        logic [CHROM_W-1:0] cc, logic [POS_W-1:0] sc, logic [POS_W-1:0] ec);
        in_beat_t t;
        t.chrom_a = ca; t.start_a = sa; t.end_a = ea;
        t.chrom_b = cb; t.start_b = sb; t.end_b = eb;
        t.chrom_c = cc; t.start_c = sc; t.end_c = ec;
        return t;
    endfunction

    // mostly near-identical intervals on one chromosome, some broken, some noise
    function automatic in_beat_t random_triple();
        logic [CHROM_W-1:0] c[3];
        logic [POS_W-1:0]   s[3];
        logic [POS_W-1:0]   e[3];
        logic [POS_W-1:0]   tmp;
        int unsigned        len, jmax, base, kind, pick, k;
        kind = $urandom_range(99);
        if (kind < 15) begin
            for (k = 0; k < 3; k++) begin
                c[k] = CHROM_W'($urandom());
                s[k] = POS_W'($urandom());
                e[k] = POS_W'($urandom());
            end
            if ($urandom_range(1)) begin
                c[1] = c[0];
                c[2] = c[0];
            end
        end else begin
            len  = ($urandom_range(9) == 0) ? $urandom_range(1 << 24, 1)
                                            : $urandom_range(4000, 1);
            jmax = len >> $urandom_range(7, 2);
            base = $urandom_range(32'h7EFF_FFFF);
            c[0] = CHROM_W'($urandom());
            for (k = 0; k < 3; k++) begin
                c[k] = c[0];
                s[k] = POS_W'(base + $urandom_range(jmax));
                e[k] = POS_W'(base + len - $urandom_range(jmax));
            end
            if (kind >= 85) begin
                pick = $urandom_range(2);
                case (break_kind_e'($urandom_range(4)))
                    BREAK_CHROM: begin
                        c[pick] = c[pick] ^ (CHROM_W'(1) << $urandom_range(CHROM_W - 1));
                    end
                    BREAK_REVERSE: begin
                        tmp = s[pick];
                        s[pick] = e[pick];
                        e[pick] = tmp;
                    end
                    BREAK_EMPTY: begin
                        e[pick] = s[pick];
                    end
                    BREAK_APART: begin
                        s[pick] = e[(pick + 1) % 3] + POS_W'($urandom_range(1000, 1));
                        e[pick] = s[pick] + POS_W'(len);
                    end
                    default: begin
                        tmp = (e[(pick + 1) % 3] < e[(pick + 2) % 3]) ? e[(pick + 1) % 3]
                                                                       : e[(pick + 2) % 3];
                        s[pick] = tmp;
                        e[pick] = tmp + POS_W'(len);
                    end
                endcase
            end
        end
        return make_triple(c[0], s[0], e[0], c[1], s[1], e[1], c[2], s[2], e[2]);
    endfunction

    task automatic send_triple(input in_beat_t beat);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (s_ready !== 1'b1);
        pending_results.insert(pending_results.size(), predict_overlap(beat));
        triples_sent++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (PIPE_LATENCY + 4) @(posedge aclk);
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_RATIO_THRESHOLD: ratio_threshold_q = value[RATIO_W-1:0];
            CFG_DISTANCE_LIMIT:  distance_limit_q  = value[DIST_W-1:0];
            default: ;
        endcase
    endtask

    task automatic compare_field(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("result %0d: %s expected %0d, got %0d", results_seen, field, want, got);
        end
    endtask

    task automatic check_result(input out_beat_t got);
        out_beat_t want;
        results_seen++;
        if (got.match === 1'b1) matches_seen++;
        if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("result %0d: unexpected beat %h", results_seen, got);
        end else begin
            want = pending_results.pop_front();
            compare_field("match",        64'(want.match),        64'(got.match));
            compare_field("length_a",     64'(want.length_a),     64'(got.length_a));
            compare_field("length_b",     64'(want.length_b),     64'(got.length_b));
            compare_field("length_c",     64'(want.length_c),     64'(got.length_c));
            compare_field("ratio_a",      64'(want.ratio_a),      64'(got.ratio_a));
            compare_field("ratio_b",      64'(want.ratio_b),      64'(got.ratio_b));
            compare_field("ratio_c",      64'(want.ratio_c),      64'(got.ratio_c));
            compare_field("distance_sum", 64'(want.distance_sum), 64'(got.distance_sum));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid === 1'b1 && m_ready) check_result(m_data);
            m_ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic test_directed_cases();
        send_triple(make_triple('0, '0, '0, '0, '0, '0, '0, '0, '0));
        send_triple(make_triple('1, POS_MAX, POS_MAX, '1, POS_MAX, POS_MAX,
                                '1, POS_MAX, POS_MAX));
        send_triple(make_triple('1, '0, POS_MAX, '1, '0, POS_MAX, '1, '0, POS_MAX));
        send_triple(make_triple(5, 100, 200, 5, 100, 200, 5, 100, 200));
        send_triple(make_triple(5, 100, 200, 5, 100, 200, 6, 100, 200));
        send_triple(make_triple(5, 200, 100, 5, 100, 200, 5, 100, 200));
        send_triple(make_triple(5, 0, 100, 5, 200, 300, 5, 0, 300));
        // touching: common overlap is a single point
        send_triple(make_triple(5, 0, 100, 5, 100, 200, 5, 50, 150));
        settle();
        // distance exactly at the limit, then two past it
        send_triple(make_triple(7, 0, 100000, 7, 0, 100000, 7, 2500, 100000));
        send_triple(make_triple(7, 0, 100000, 7, 0, 100000, 7, 2501, 100000));
        send_triple(make_triple(9, 0, 0, 9, POS_MAX, POS_MAX, 9, 0, POS_MAX));
        send_triple(make_triple(16'h1234, 31'h7FFF_0000, POS_MAX, 16'h1234, 31'h7FFF_0000,
                                POS_MAX, 16'h1234, 31'h7FFF_0000, POS_MAX));
        settle();
    endtask

    task automatic test_ratio_boundary();
        set_register(CFG_DISTANCE_LIMIT, '1);
        send_triple(make_triple(3, 0, 65536, 3, 0, 65536, 3, 0, 58982));
        send_triple(make_triple(3, 0, 65536, 3, 0, 65536, 3, 0, 58983));
        settle();
        set_register(CFG_NO_SUCH_REG, '0);
        send_triple(make_triple(3, 0, 65536, 3, 0, 65536, 3, 0, 58982));
        settle();
        set_register(CFG_RATIO_THRESHOLD, CFG_DATA_W'(58981));
        send_triple(make_triple(3, 0, 65536, 3, 0, 65536, 3, 0, 58982));
        settle();
    endtask

    task automatic apply_setting(input int unsigned k);
        case (k % 4)
            0: begin
                set_register(CFG_RATIO_THRESHOLD, '0);
                set_register(CFG_DISTANCE_LIMIT, '1);
            end
            1: begin
                // upper bits must be dropped, leaving a threshold of 1.0
                set_register(CFG_RATIO_THRESHOLD, {17'h1FFFF, 17'h10000});
                set_register(CFG_DISTANCE_LIMIT, '0);
            end
            2: begin
                set_register(CFG_RATIO_THRESHOLD, CFG_DATA_W'($urandom_range(65535, 52000)));
                set_register(CFG_DISTANCE_LIMIT, CFG_DATA_W'($urandom_range(20000)));
            end
            default: begin
                set_register(CFG_IDX_W'($urandom_range(255, 2)), CFG_DATA_W'($urandom()));
                set_register(CFG_RATIO_THRESHOLD, RATIO_THRESHOLD_RESET);
                set_register(CFG_DISTANCE_LIMIT, DISTANCE_LIMIT_RESET);
            end
        endcase
    endtask

    task automatic test_random_traffic(input int unsigned src_pct, input int unsigned snk_pct,
                                       input int unsigned first_setting);
        int unsigned seg;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        for (seg = 0; seg < 3; seg++) begin
            settle();
            apply_setting(first_setting + seg);
            repeat (ITEMS_PER_SEG) send_triple(random_triple());
        end
        settle();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_ratio_boundary();
        test_random_traffic(27, 73, 0);
        test_random_traffic(73, 27, 3);
        test_random_traffic(0, 0, 6);

        mismatches += pending_results.size();
        $display("%0d triples checked (%0d matched): directed corners, threshold edges,",
                 results_seen, matches_seen);
        $display("nine register settings and three stall mixes; %0d mismatches", mismatches);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
